/* hw/rtl/lwr_pkg.sv */
`default_nettype none
package lwr_pkg;
    typedef enum logic [2:0] {
        MODE_LOAD  = 3'd0,
        MODE_COUNT = 3'd1,
        MODE_DOWN  = 3'd2,
        MODE_UP    = 3'd3,
        MODE_ISDN  = 3'd4,
        MODE_LEAVE = 3'd5,
        MODE_WGT   = 3'd6,
        MODE_NOP   = 3'd7
    } mode_t;

    localparam int unsigned CFG_W   = 5;
    localparam int unsigned EFF_W   = 19;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned PROF_W  = 3;
    localparam int unsigned WAN_W   = 4;
    localparam int unsigned POS_W   = 3;
    localparam int unsigned WIN_W   = 16;
    localparam int unsigned CNT_W   = 4;
endpackage
`default_nettype wire

/* hw/rtl/lwr_ram.sv */
`default_nettype none
module lwr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hw/rtl/lwr_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle.
// done rises when the quotient is ready and stays high until the next start.
module lwr_div #(
    parameter int unsigned NW = 20,
    parameter int unsigned DW = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic      [NW-1:0] quo,
    output logic      [DW-1:0] rem
);
    localparam int unsigned CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW:0]   shifted;
    logic          fits;

    assign shifted = {r_reg[DW-1:0], q_reg[NW-1]};
    assign fits    = shifted >= {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
                done     <= 1'b0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[NW-2:0], fits};
            r_reg <= fits ? shifted - {1'b0, den} : shifted;
        end
    end

    assign quo = q_reg;
    assign rem = r_reg[DW-1:0];
endmodule
`default_nettype wire

/* hw/rtl/link_weight_redistributor.sv */
`default_nettype none
// Link weight redistributor. One command is taken per transfer and yields
// exactly one result transfer. Admin commands (load, count, down, up, is
// down) go from the execute state straight to the output state. A
// would-leave query walks the profile's list once through the link memory,
// with a read-issue state and a data state per position. A weight query
// walks the list twice (sum of down weights and up count, then the rank of
// the target) and runs a bit-serial division of the down sum by the up
// count alongside the second walk; it stops after the first walk if the
// target is not found or the up count or down sum is zero. The link list
// lives in one synchronous RAM (one read/write port pair, one read per
// cycle); down masks and counts are small register files. The output
// register holds a result until taken, and the next command is accepted
// only after that.
module link_weight_redistributor #(
    parameter int unsigned PROFILES    = 8,
    parameter int unsigned LINKS       = 8,
    parameter int unsigned WANS        = 16,
    parameter int unsigned WEIGHT_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [lwr_pkg::CFG_W-1:0]   cfg_wdata,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [lwr_pkg::MODE_W-1:0]  mode,
    input  wire logic [lwr_pkg::PROF_W-1:0]  profile,
    input  wire logic [lwr_pkg::WAN_W-1:0]   wan,
    input  wire logic [lwr_pkg::POS_W-1:0]   position,
    input  wire logic [lwr_pkg::WIN_W-1:0]   weight,
    input  wire logic [lwr_pkg::CNT_W-1:0]   link_count,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             status,
    output logic                             flag,
    output logic [lwr_pkg::EFF_W-1:0]        eff_weight
);
    import lwr_pkg::*;

    localparam int unsigned PI_W  = (PROFILES > 1) ? $clog2(PROFILES) : 1;
    localparam int unsigned LI_W  = (LINKS > 1) ? $clog2(LINKS) : 1;
    localparam int unsigned LC_W  = $clog2(LINKS + 1);
    localparam int unsigned DEPTH = PROFILES * LINKS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned WW    = $clog2(WANS + 1) > WAN_W ? $clog2(WANS + 1) : WAN_W;
    localparam int unsigned SW    = WEIGHT_BITS + LC_W;
    localparam int unsigned RW    = WAN_W + WEIGHT_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EXEC, ST_W1, ST_W1D, ST_FIND, ST_W2, ST_W2D, ST_DIV, ST_DIVW,
        ST_LV, ST_LVD, ST_OUT
    } state_t;

    state_t state_reg;

    logic [WANS-1:0]  down_reg [PROFILES];
    logic [LC_W-1:0]  used_reg [PROFILES];
    logic [CFG_W-1:0] total_reg;

    logic [MODE_W-1:0] mode_reg;
    logic [PROF_W-1:0] prof_reg;
    logic [WAN_W-1:0]  wan_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [WIN_W-1:0]  wt_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [LC_W-1:0]        idx_reg;
    logic [SW-1:0]          sum_reg;
    logic [LC_W-1:0]        nup_reg;
    logic [LC_W-1:0]        rank_reg;
    logic                   found_reg;
    logic                   ranked_reg;
    logic [WEIGHT_BITS-1:0] self_reg;
    logic [SW-1:0]          share_reg;
    logic [LC_W-1:0]        rem_reg;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [AW-1:0]  ram_raddr;
    logic [RW-1:0]  ram_wdata;
    logic [RW-1:0]  ram_rdata;
    logic [WAN_W-1:0]       rd_wan;
    logic [WEIGHT_BITS-1:0] rd_wt;

    logic [WW-1:0]   lim;
    logic            bad;
    logic            prof_ok;
    logic [PI_W-1:0] pidx;
    logic [WANS-1:0] dmask;
    logic [LC_W-1:0] nused;
    logic            rd_valid;
    logic            rd_down;
    logic            tgt_down;
    logic            div_start;
    logic            div_done;
    logic [SW-1:0]   div_q;
    logic [LC_W-1:0] div_r;
    logic [SW:0]     eff_sum;

    assign lim     = (WW'(total_reg) < WW'(WANS)) ? WW'(total_reg) : WW'(WANS);
    assign bad     = WW'(wan_reg) >= lim;
    assign prof_ok = 32'(prof_reg) < PROFILES;
    assign pidx    = PI_W'(prof_reg);
    assign dmask   = down_reg[pidx];
    assign nused   = used_reg[pidx];
    assign rd_wan  = ram_rdata[RW-1 -: WAN_W];
    assign rd_wt   = ram_rdata[WEIGHT_BITS-1:0];
    assign rd_valid = WW'(rd_wan) < lim;
    assign rd_down  = (32'(rd_wan) < WANS) ? dmask[rd_wan] : 1'b0;
    assign tgt_down = (32'(wan_reg) < WANS) ? dmask[wan_reg] : 1'b0;

    assign ram_we    = (state_reg == ST_EXEC) && prof_ok && (mode_reg == MODE_LOAD)
                       && (32'(pos_reg) < LINKS);
    assign ram_waddr = AW'(32'(pidx) * LINKS + 32'(pos_reg));
    assign ram_wdata = {wan_reg, WEIGHT_BITS'(wt_reg)};
    assign ram_raddr = AW'(32'(pidx) * LINKS + 32'(LI_W'(idx_reg)));
    assign div_start = (state_reg == ST_DIV);
    assign eff_sum   = (SW + 1)'(self_reg) + (SW + 1)'(share_reg)
                       + (SW + 1)'(rank_reg < rem_reg);

    lwr_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_links (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lwr_div #(.NW(SW), .DW(LC_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sum_reg),
        .den   (nup_reg),
        .done  (div_done),
        .quo   (div_q),
        .rem   (div_r)
    );

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            total_reg <= CFG_W'(16);
            out_valid <= 1'b0;
            for (int p = 0; p < PROFILES; p++)
            begin
                down_reg[p] <= '0;
                used_reg[p] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                total_reg <= cfg_wdata;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg  <= mode;
                        prof_reg  <= profile;
                        wan_reg   <= wan;
                        pos_reg   <= position;
                        wt_reg    <= weight;
                        cnt_reg   <= link_count;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    eff_weight <= '0;
                    idx_reg    <= '0;
                    sum_reg    <= '0;
                    nup_reg    <= '0;
                    rank_reg   <= '0;
                    found_reg  <= 1'b0;
                    ranked_reg <= 1'b0;
                    status     <= prof_ok && (mode_reg != MODE_NOP)
                                  && (mode_reg != MODE_COUNT) && bad;
                    flag       <= prof_ok && (mode_reg == MODE_ISDN) && !bad && tgt_down;
                    priority if (prof_ok && !bad && !tgt_down && mode_reg == MODE_LEAVE)
                    begin
                        state_reg <= ST_LV;
                    end
                    else if (prof_ok && !bad && !tgt_down && mode_reg == MODE_WGT)
                    begin
                        state_reg <= ST_W1;
                    end
                    else
                    begin
                        state_reg <= ST_OUT;
                    end
                    if (prof_ok)
                    begin
                        unique case (mode_t'(mode_reg))
                            MODE_COUNT:
                                used_reg[pidx] <= (32'(cnt_reg) < LINKS) ?
                                                  LC_W'(cnt_reg) : LC_W'(LINKS);
                            MODE_DOWN:
                                if (!bad) down_reg[pidx][wan_reg] <= 1'b1;
                            MODE_UP:
                                if (!bad) down_reg[pidx][wan_reg] <= 1'b0;
                            default: ;
                        endcase
                    end
                end
                // would-leave walk: read issue, then data
                ST_LV:
                begin
                    if (idx_reg >= nused)
                    begin
                        flag      <= nup_reg <= LC_W'(1);
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_LVD;
                    end
                end
                ST_LVD:
                begin
                    if (rd_valid && !rd_down) nup_reg <= nup_reg + 1'b1;
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= ST_LV;
                end
                // pass 1: find self, sum down weights, count up links
                ST_W1:
                begin
                    if (idx_reg >= nused)
                    begin
                        if (!found_reg)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else if (nup_reg == '0 || sum_reg == '0)
                        begin
                            eff_weight <= EFF_W'(self_reg);
                            state_reg  <= ST_OUT;
                        end
                        else
                        begin
                            idx_reg   <= '0;
                            state_reg <= ST_DIV;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_W1D;
                    end
                end
                ST_W1D:
                begin
                    if (!found_reg && rd_wan == wan_reg)
                    begin
                        found_reg <= 1'b1;
                        self_reg  <= rd_wt;
                    end
                    if (rd_valid)
                    begin
                        if (rd_down) sum_reg <= sum_reg + SW'(rd_wt);
                        else         nup_reg <= nup_reg + 1'b1;
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= ST_W1;
                end
                ST_DIV:
                begin
                    state_reg <= ST_W2;
                end
                // pass 2 runs alongside the divider: rank among up links
                ST_W2:
                begin
                    if (idx_reg >= nused) state_reg <= ST_DIVW;
                    else                  state_reg <= ST_W2D;
                end
                ST_W2D:
                begin
                    if (rd_valid && !rd_down && !ranked_reg)
                    begin
                        if (rd_wan == wan_reg) ranked_reg <= 1'b1;
                        else                   rank_reg   <= rank_reg + 1'b1;
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= ST_W2;
                end
                ST_DIVW:
                begin
                    if (div_done)
                    begin
                        share_reg <= div_q;
                        rem_reg   <= div_r;
                        state_reg <= ST_FIND;
                    end
                end
                ST_FIND:
                begin
                    eff_weight <= (eff_sum == '0) ? EFF_W'(1) : EFF_W'(eff_sum);
                    state_reg  <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid)
                    begin
                        out_valid <= 1'b1;
                    end
                    else if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(eff_weight))
        else $error("pending result changed");
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == ST_EXEC && mode_reg == MODE_LOAD)
        else $error("link write outside load");
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIND |-> div_done)
        else $error("divider result used before done");
`endif
endmodule
`default_nettype wire
